### sv/arp_responder_cache_macros.svh
// Assertion macros for the ARP cache RTL.
`ifndef ARP_RESPONDER_CACHE_MACROS_SVH
`define ARP_RESPONDER_CACHE_MACROS_SVH

// Same-cycle implication, checked on every clock outside reset.
`define ARPC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every clock outside reset.
`define ARPC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/arpc_pkg.sv
// Types and constants shared by the ARP cache and responder.
`timescale 1ns / 1ps
`default_nettype none
package arpc_pkg;

  localparam int DEFAULT_CACHE_ENTRIES = 8;
  localparam int CMDQ_DEPTH = 2;

  localparam logic [15:0] HW_ETHERNET  = 16'h0001;
  localparam logic [15:0] PROTO_IPV4   = 16'h0800;
  localparam logic [15:0] OPC_REQUEST  = 16'h0001;
  localparam logic [15:0] OPC_RESPONSE = 16'h0002;

  localparam logic OP_MESSAGE = 1'b0;
  localparam logic OP_QUERY   = 1'b1;

  localparam logic [1:0] CFG_OWN_IP  = 2'd0;
  localparam logic [1:0] CFG_OWN_MAC = 2'd1;

  localparam logic [2:0] ACT_NONE     = 3'd0;
  localparam logic [2:0] ACT_REPLY    = 3'd1;
  localparam logic [2:0] ACT_REQUEST  = 3'd2;
  localparam logic [2:0] ACT_RESOLVED = 3'd3;
  localparam logic [2:0] ACT_LEARNED  = 3'd4;

  localparam logic [47:0] MAC_BROADCAST = 48'hFFFF_FFFF_FFFF;

  // One cache entry in RAM: IP above MAC.
  localparam int ENTRY_W = 80;

  typedef struct packed {
    logic        operation;
    logic        frame_short;
    logic [15:0] hw_type;
    logic [15:0] net_proto;
    logic [15:0] msg_type;
    logic [47:0] sender_mac;
    logic [31:0] sender_ip;
    logic [31:0] target_ip;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  action;
    logic [47:0] peer_mac;
    logic [31:0] peer_ip;
  } out_item_t;

  typedef enum logic [1:0] {
    CMD_NONE,
    CMD_REPLY,
    CMD_QUERY,
    CMD_LEARN
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic [47:0] mac;
    logic [31:0] ip;
  } cmd_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_SCAN,
    B_DONE
  } back_state_t;

endpackage
`default_nettype wire

### sv/arpc_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module arpc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic [ADDR_W-1:0] raddr,
  output      logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

### sv/arpc_cmd_fifo.sv
// Short command queue between the classifier and the cache engine.
`timescale 1ns / 1ps
`default_nettype none
module arpc_cmd_fifo
  import arpc_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire cmd_t push_cmd,
  output      logic full,
  input  wire logic pop,
  output      logic q_valid,
  output      cmd_t q_cmd
);

  localparam int PTR_W = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
  localparam int CNT_W = $clog2(CMDQ_DEPTH + 1);

  cmd_t             slots [CMDQ_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full    = (count == CNT_W'(CMDQ_DEPTH));
  assign q_valid = (count != '0);
  assign q_cmd   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

endmodule
`default_nettype wire

### sv/arpc_front.sv
// Input classifier: filters received messages and turns words into cache commands.
`timescale 1ns / 1ps
`default_nettype none
module arpc_front
  import arpc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output      logic        in_stall,
  input  wire in_item_t    in_data,
  input  wire logic        cfg_valid,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [47:0] cfg_data,
  input  wire logic        q_full,
  output      logic        push,
  output      cmd_t        push_cmd
);

  logic [31:0] own_ip;
  logic        addressed;

  // own_mac is not used in this block; drop its writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      own_ip <= '0;
    end else if (cfg_valid && cfg_index == CFG_OWN_IP) begin
      own_ip <= cfg_data[31:0];
    end
  end

  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

  assign addressed = !in_data.frame_short && in_data.hw_type == HW_ETHERNET &&
                     in_data.net_proto == PROTO_IPV4 && in_data.target_ip == own_ip;

  always_comb begin
    push_cmd.kind = CMD_NONE;
    push_cmd.mac  = in_data.sender_mac;
    push_cmd.ip   = in_data.sender_ip;
    priority if (in_data.operation == OP_QUERY) begin
      push_cmd.kind = CMD_QUERY;
      push_cmd.ip   = in_data.target_ip;
    end else if (!addressed) begin
      push_cmd.kind = CMD_NONE;
    end else if (in_data.msg_type == OPC_REQUEST) begin
      push_cmd.kind = CMD_REPLY;
    end else if (in_data.msg_type == OPC_RESPONSE) begin
      push_cmd.kind = CMD_LEARN;
    end else begin
      push_cmd.kind = CMD_NONE;
    end
  end

endmodule
`default_nettype wire

### sv/arpc_back.sv
// Cache engine: scans the cache RAM, learns new entries and drives the result register.
`timescale 1ns / 1ps
`default_nettype none
`include "arp_responder_cache_macros.svh"
module arpc_back
  import arpc_pkg::*;
#(
  parameter int CACHE_ENTRIES = DEFAULT_CACHE_ENTRIES
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      q_valid,
  input  wire cmd_t      q_cmd,
  output      logic      pop,
  output      logic      out_valid,
  input  wire logic      out_stall,
  output      out_item_t out_data
);

  localparam int IDX_W = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CACHE_ENTRIES - 1);

  back_state_t              state, state_next;
  cmd_t                     cur;
  logic [CACHE_ENTRIES-1:0] valid;
  logic [IDX_W-1:0]         write_slot;
  logic [IDX_W-1:0]         scan_idx, scan_idx_next;
  logic                     issue_done, issue_done_next;
  logic [IDX_W-1:0]         chk_idx;
  logic                     chk_vld, chk_vld_next;
  logic                     found, found_next;
  logic [47:0]              found_mac, found_mac_next;
  logic [ENTRY_W-1:0]       rdata;
  logic [31:0]              entry_ip;
  logic [47:0]              entry_mac;
  logic                     learn_we;
  logic                     out_free;
  logic                     issue;
  out_item_t                result;

  arpc_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(CACHE_ENTRIES)
  ) u_cache (
    .clk  (clk),
    .we   (learn_we),
    .waddr(write_slot),
    .wdata({cur.ip, cur.mac}),
    .raddr(scan_idx),
    .rdata(rdata)
  );

  // Entries never written read as the cleared value.
  assign entry_ip  = valid[chk_idx] ? rdata[ENTRY_W-1:48] : '0;
  assign entry_mac = valid[chk_idx] ? rdata[47:0] : '0;

  assign out_free = !out_valid || !out_stall;
  assign issue    = (state == B_SCAN) && !issue_done;
  assign learn_we = (state == B_DONE) && cur.kind == CMD_LEARN && !found;

  always_comb begin
    state_next      = state;
    scan_idx_next   = scan_idx;
    issue_done_next = issue_done;
    chk_vld_next    = 1'b0;
    found_next      = found;
    found_mac_next  = found_mac;
    pop             = 1'b0;
    unique case (state)
      B_IDLE: begin
        if (q_valid && out_free) begin
          pop             = 1'b1;
          scan_idx_next   = '0;
          issue_done_next = 1'b0;
          found_next      = 1'b0;
          found_mac_next  = '0;
          if (q_cmd.kind == CMD_QUERY || q_cmd.kind == CMD_LEARN) begin
            state_next = B_SCAN;
          end else begin
            state_next = B_DONE;
          end
        end
      end
      B_SCAN: begin
        // Keep one read in flight while checking the word that just came back.
        if (issue) begin
          if (scan_idx == LAST_IDX) begin
            issue_done_next = 1'b1;
          end else begin
            scan_idx_next = scan_idx + 1'b1;
          end
        end
        if (chk_vld && entry_ip == cur.ip) begin
          found_next     = 1'b1;
          found_mac_next = entry_mac;
          state_next     = B_DONE;
        end else if (chk_vld && chk_idx == LAST_IDX) begin
          state_next = B_DONE;
        end else begin
          chk_vld_next = issue;
        end
      end
      B_DONE: begin
        state_next = B_IDLE;
      end
      default: begin
        state_next = B_IDLE;
      end
    endcase
  end

  always_comb begin
    result.action   = ACT_NONE;
    result.peer_mac = '0;
    result.peer_ip  = '0;
    unique case (cur.kind)
      CMD_NONE: begin
        result.action = ACT_NONE;
      end
      CMD_REPLY: begin
        result.action   = ACT_REPLY;
        result.peer_mac = cur.mac;
        result.peer_ip  = cur.ip;
      end
      CMD_QUERY: begin
        result.action   = found ? ACT_RESOLVED : ACT_REQUEST;
        result.peer_mac = found ? found_mac : MAC_BROADCAST;
        result.peer_ip  = cur.ip;
      end
      CMD_LEARN: begin
        if (!found) begin
          result.action   = ACT_LEARNED;
          result.peer_mac = cur.mac;
          result.peer_ip  = cur.ip;
        end
      end
      default: begin
        result.action = ACT_NONE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= B_IDLE;
      valid      <= '0;
      write_slot <= '0;
      chk_vld    <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state   <= state_next;
      chk_vld <= chk_vld_next;
      if (learn_we) begin
        valid[write_slot] <= 1'b1;
        write_slot <= (write_slot == LAST_IDX) ? '0 : write_slot + 1'b1;
      end
      if (state == B_DONE) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    scan_idx   <= scan_idx_next;
    issue_done <= issue_done_next;
    chk_idx    <= scan_idx;
    found      <= found_next;
    found_mac  <= found_mac_next;
    if (pop) begin
      cur <= q_cmd;
    end
    if (state == B_DONE) begin
      out_data <= result;
    end
  end

  `ARPC_ASSERT_NOW(a_pop_idle, pop, state == B_IDLE && q_valid, "pop outside idle")
  `ARPC_ASSERT_NOW(a_done_free, state == B_DONE, !out_valid, "result register still full")
  `ARPC_ASSERT_NEXT(a_done_once, state == B_DONE, state == B_IDLE, "done held past one cycle")
  `ARPC_ASSERT_NEXT(a_learn_sets, learn_we, valid[$past(write_slot)], "learned slot not valid")

endmodule
`default_nettype wire

### sv/arp_responder_cache.sv
// Top level of the ARP cache and responder.
// Parsed ARP messages and resolve queries enter as one word each and give one result word
// each, in order. A classifier checks frame length, hardware and protocol type and the
// target IP against own_ip, then queues a command in a two-deep queue; the cache engine
// behind it takes one command at a time. A dropped message, an unknown opcode or a request
// goes from idle straight to the done state, which loads the result register. A resolve
// query or a response addressed to us scans the cache RAM one entry per cycle through its
// single read port, stopping at the first match or after the last entry, and then loads
// the result register in the done state. The engine takes no new command while the result
// register holds a word the receiver has not taken. Entries carry valid bits cleared by
// reset, so no clearing pass is needed after reset; unwritten entries read as IP 0 and
// MAC 0. own_mac is accepted on the configuration port but is not used here. The
// configuration port is always ready.
`timescale 1ns / 1ps
`default_nettype none
module arp_responder_cache
  import arpc_pkg::*;
#(
  parameter int CACHE_ENTRIES = DEFAULT_CACHE_ENTRIES
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output      logic        in_stall,
  input  wire in_item_t    in_data,
  output      logic        out_valid,
  input  wire logic        out_stall,
  output      out_item_t   out_data,
  input  wire logic        cfg_valid,
  output      logic        cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [47:0] cfg_data
);

  logic push;
  cmd_t push_cmd;
  logic q_full;
  logic q_valid;
  cmd_t q_cmd;
  logic pop;

  assign cfg_ready = 1'b1;

  arpc_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .cfg_valid(cfg_valid && cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .q_full   (q_full),
    .push     (push),
    .push_cmd (push_cmd)
  );

  arpc_cmd_fifo u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_cmd(push_cmd),
    .full    (q_full),
    .pop     (pop),
    .q_valid (q_valid),
    .q_cmd   (q_cmd)
  );

  arpc_back #(
    .CACHE_ENTRIES(CACHE_ENTRIES)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd),
    .pop      (pop),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

endmodule
`default_nettype wire
